[src/tccs_pkg.sv]
// ----------------------------------------------------------------------------
// tccs_pkg - shared types and constants of the text console engine
// Command codes, sequencer states, field widths and control structs.
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int CELLS_DEF   = COLUMNS_DEF * ROWS_DEF;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int IDX_W  = 11;
  localparam int OCOL_W = 7;
  localparam int OROW_W = 5;
  localparam int OPOS_W = 11;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_RDWAIT
  } state_t;

  // cursor commands from the sequencer
  typedef struct packed {
    logic home;
    logic advance;
    logic newline;
  } cursor_ctl_t;

endpackage

[src/tccs_ram.sv]
// ----------------------------------------------------------------------------
// tccs_ram - generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tccs_ram
  import tccs_pkg::*;
#(
  parameter int WIDTH = CELL_W,
  parameter int DEPTH = CELLS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/tccs_cursor.sv]
// ----------------------------------------------------------------------------
// tccs_cursor - cursor registers and advance logic
// Holds column and row, advances on put, homes on clear, reports linear position.
// ----------------------------------------------------------------------------
module tccs_cursor
  import tccs_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  localparam int COL_W  = $clog2(COLUMNS),
  localparam int ROW_W  = $clog2(ROWS),
  localparam int AW     = $clog2(COLUMNS * ROWS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cursor_ctl_t      ctl,
  output logic             scroll,
  output logic [COL_W-1:0] col,
  output logic [ROW_W-1:0] row,
  output logic [AW-1:0]    pos
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             wrap;
  logic             step_row;

  assign wrap     = (col_r == COL_W'(COLUMNS - 1));
  assign step_row = ctl.newline | wrap;
  // advancing past the bottom row scrolls
  assign scroll   = step_row && (row_r == ROW_W'(ROWS - 1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (ctl.home) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (ctl.advance) begin
      col_nxt = step_row ? '0 : col_r + COL_W'(1);
      if (step_row && !scroll) begin
        row_nxt = row_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col = col_r;
  assign row = row_r;
  assign pos = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);

endmodule

[src/tccs_ctrl.sv]
// ----------------------------------------------------------------------------
// tccs_ctrl - command sequencer and store address unit
// Decodes requests, sweeps the cell store for clear and scroll, holds results.
// ----------------------------------------------------------------------------
module tccs_ctrl
  import tccs_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int AW     = $clog2(CELLS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [ATTR_W-1:0] attr,
  input  logic [IDX_W-1:0]  cell_index,
  input  logic              cfg_wr_en,
  input  logic [ATTR_W-1:0] cfg_wr_data,
  output cursor_ctl_t       cur_ctl,
  input  logic              cur_scroll,
  input  logic [AW-1:0]     cur_pos,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [CELL_W-1:0] ram_wdata,
  output logic [AW-1:0]     ram_raddr,
  input  logic [CELL_W-1:0] ram_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] read_char,
  output logic [ATTR_W-1:0] read_attr,
  output logic              scrolled
);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;
  logic [ATTR_W-1:0] fill_attr_r;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] rchar_r, rchar_nxt;
  logic [ATTR_W-1:0] rattr_r, rattr_nxt;
  logic              scrolled_r, scrolled_nxt;

  logic accept;
  logic last;
  logic idx_ok;
  logic newline;
  cmd_t cmd;

  assign cmd     = cmd_t'(command);
  assign last    = (cnt_r == AW'(CELLS - 1));
  assign idx_ok  = (32'(cell_index) < 32'(CELLS));
  assign newline = (char_code == NEWLINE_CHAR);
  assign accept  = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_PUT:   state_nxt = cur_scroll ? ST_COPY : ST_IDLE;
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_READ:  state_nxt = idx_ok ? ST_RDWAIT : ST_IDLE;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (last) state_nxt = ST_IDLE;
      end
      ST_COPY: begin
        if (last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_BLANK;
      ST_BLANK: begin
        if (last) state_nxt = ST_IDLE;
      end
      ST_RDWAIT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    in_ready      = 1'b0;
    cur_ctl       = '0;
    ram_we        = 1'b0;
    ram_waddr     = cur_pos;
    ram_wdata     = {attr, char_code};
    ram_raddr     = cnt_r;
    cnt_nxt       = cnt_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rchar_nxt     = rchar_r;
    rattr_nxt     = rattr_r;
    scrolled_nxt  = scrolled_r;
    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = {RESET_ATTR, BLANK_CHAR};
        cnt_nxt   = last ? '0 : cnt_r + AW'(1);
      end
      ST_IDLE: begin
        in_ready        = !out_valid_r || out_ready;
        ram_raddr       = AW'(cell_index);
        cur_ctl.newline = newline;
        if (accept) begin
          rchar_nxt    = '0;
          rattr_nxt    = '0;
          scrolled_nxt = 1'b0;
          case (cmd)
            CMD_PUT: begin
              cur_ctl.advance = 1'b1;
              ram_we          = !newline;
              if (cur_scroll) begin
                cnt_nxt = AW'(COLUMNS);
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            CMD_CLEAR: begin
              cur_ctl.home = 1'b1;
              cnt_nxt      = '0;
            end
            CMD_READ: begin
              out_valid_nxt = !idx_ok;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = {fill_attr_r, BLANK_CHAR};
        cnt_nxt   = last ? '0 : cnt_r + AW'(1);
        if (last) out_valid_nxt = 1'b1;
      end
      ST_COPY: begin
        // read one row ahead, write the previous read back one row up
        ram_we      = wr_pend_r;
        ram_waddr   = wr_addr_r;
        ram_wdata   = ram_rdata;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = cnt_r - AW'(COLUMNS);
        cnt_nxt     = last ? AW'(CELLS - COLUMNS) : cnt_r + AW'(1);
      end
      ST_DRAIN: begin
        ram_we    = 1'b1;
        ram_waddr = wr_addr_r;
        ram_wdata = ram_rdata;
      end
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = {fill_attr_r, BLANK_CHAR};
        cnt_nxt   = last ? '0 : cnt_r + AW'(1);
        if (last) begin
          out_valid_nxt = 1'b1;
          scrolled_nxt  = 1'b1;
        end
      end
      ST_RDWAIT: begin
        out_valid_nxt = 1'b1;
        rchar_nxt     = ram_rdata[CHAR_W-1:0];
        rattr_nxt     = ram_rdata[CELL_W-1:CHAR_W];
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      wr_pend_r   <= 1'b0;
      fill_attr_r <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) fill_attr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r  <= wr_addr_nxt;
    rchar_r    <= rchar_nxt;
    rattr_r    <= rattr_nxt;
    scrolled_r <= scrolled_nxt;
  end

  assign out_valid = out_valid_r;
  assign read_char = rchar_r;
  assign read_attr = rattr_r;
  assign scrolled  = scrolled_r;

endmodule

[src/text_console_cursor_scroll_unit.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit - text console cell store with cursor
// Character/attribute store with put, clear, read and scroll-on-overflow.
// ----------------------------------------------------------------------------
// The console keeps COLUMNS x ROWS cells (character in the low byte, attribute
// in the high byte) in one memory with a registered read port. After reset the
// block sweeps the whole store to spaces in attribute 0x0F, one cell a cycle,
// and accepts no request until done. A put that does not scroll, and an unused
// command code, are answered from the idle state, and the next request can be
// taken as soon as the result leaves. A read waits in ST_RDWAIT for the
// registered memory read. A clear sweeps the store once with fill_attr. A put
// that runs past the bottom row moves every row up through the memory's single
// read and write port, one cell a cycle, then blanks the bottom row. The cursor
// fields of every result show the cursor after the request; fill_attr may only
// be written while no request is in flight.
module text_console_cursor_scroll_unit
  import tccs_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char_code[7:0], attr[15:8], cell_index[26:16]
  input  logic [1:0]  in_tuser,   // command[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // cursor_column[6:0], cursor_row[11:7],
                                  // cursor_position[22:12], read_char[30:23],
                                  // read_attr[38:31], scrolled[39]
  // fill attribute register
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);

  // request fields
  logic [CHAR_W-1:0] char_code;
  logic [ATTR_W-1:0] attr;
  logic [IDX_W-1:0]  cell_index;

  assign char_code  = in_tdata[7:0];
  assign attr       = in_tdata[15:8];
  assign cell_index = in_tdata[26:16];

  // sequencer to cursor
  cursor_ctl_t      cur_ctl;
  logic             cur_scroll;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [AW-1:0]    cur_pos;

  // cell store port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // result payload held by the sequencer
  logic [CHAR_W-1:0] read_char;
  logic [ATTR_W-1:0] read_attr;
  logic              scrolled;

  tccs_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .command     (in_tuser),
    .char_code   (char_code),
    .attr        (attr),
    .cell_index  (cell_index),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cur_ctl     (cur_ctl),
    .cur_scroll  (cur_scroll),
    .cur_pos     (cur_pos),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .read_char   (read_char),
    .read_attr   (read_attr),
    .scrolled    (scrolled)
  );

  tccs_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (cur_ctl),
    .scroll (cur_scroll),
    .col    (cur_col),
    .row    (cur_row),
    .pos    (cur_pos)
  );

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // cursor only moves when a request is taken and the result slot is free,
  // so the result can show the live cursor registers
  assign out_tdata = {scrolled, read_attr, read_char, OPOS_W'(cur_pos),
                      OROW_W'(cur_row), OCOL_W'(cur_col)};

endmodule
